### rtl/dso_pkg.sv
// shared types and constants for the dhcp snooping option parser
`timescale 1ns / 1ps
package dso_pkg;
	localparam int HostBytes = 32;
	localparam int OptBytes = 312;
	localparam logic [7:0] OptPad = 8'd0;
	localparam logic [7:0] OptEnd = 8'd255;
	localparam logic [7:0] OptLease = 8'd51;
	localparam logic [7:0] OptHost = 8'd12;
	localparam logic [7:0] OptType = 8'd53;
	localparam logic [7:0] PrivReset = 8'd224;
	localparam logic [7:0] MtDiscover = 8'd1;
	localparam logic [7:0] MtOffer = 8'd2;
	localparam logic [7:0] MtRequest = 8'd3;
	localparam logic [7:0] MtAck = 8'd5;
	localparam logic [7:0] MtNak = 8'd6;
	localparam logic [7:0] MtRelease = 8'd7;
	localparam logic [15:0] OptFirst = 16'd240;
	localparam logic [15:0] OptLimit = 16'(236 + OptBytes);

	typedef enum logic [2:0] {
		PH_CODE = 3'b001,
		PH_LEN = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] msg_type;
		logic [31:0] lease_secs;
		logic [31:0] station_ip;
		logic station_ip_valid;
		logic [47:0] station_mac;
		logic [47:0] relay_mac;
		logic [31:0] iface_tag;
		logic [5:0] hostname_length;
		logic [2:0] chunks;
		logic names;
	} summary_t;
endpackage

### rtl/dso_parse.sv
// per-byte parse state: header skip, bootp capture and option walk
`timescale 1ns / 1ps
module dso_parse import dso_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] pbyte,
	input logic plast,
	input logic [7:0] priv_code,
	output summary_t summ,
	output logic [HostBytes*8-1:0] hname
);
	logic [15:0] pos_q;
	logic [5:0] hlen_q;
	logic [31:0] caddr_q, yaddr_q, iface_q, lease_q;
	logic [47:0] chw_q, uplink_q;
	phase_t phase_q;
	logic [7:0] code_q, olen_q, ooff_q, type_q;
	logic [7:0] host_q [HostBytes];
	logic [5:0] hcnt_q;
	logic done_q;

	logic [5:0] hl;
	logic [15:0] start, o;
	logic in_opt;
	logic is_priv;
	logic [8:0] off1;

	always_comb begin
		hl = (pos_q == 16'd0) ? {pbyte[3:0], 2'b00} : hlen_q;
		start = 16'(hl) + 16'd8;
		o = pos_q - start;
		in_opt = (pos_q != 16'd0) && (pos_q >= start) && (o >= OptFirst) && (o < OptLimit)
			&& !done_q;
		is_priv = (code_q == priv_code);
		off1 = {1'b0, ooff_q} + 9'd1;
	end

	// summary chosen by message type from the state after this byte
	logic [31:0] caddr_n, yaddr_n, iface_n, lease_n;
	logic [47:0] chw_n, uplink_n;
	logic [7:0] type_n;
	logic [5:0] hcnt_n;
	logic [7:0] host_n [HostBytes];
	logic act;
	logic [2:0] nch;

	always_comb begin
		caddr_n = caddr_q; yaddr_n = yaddr_q; chw_n = chw_q;
		iface_n = iface_q; lease_n = lease_q; uplink_n = uplink_q;
		type_n = type_q; hcnt_n = hcnt_q;
		host_n = host_q;
		nch = '0;
		act = (pos_q != 16'd0) && (pos_q >= start);
		if (act && o >= 16'd12 && o <= 16'd15) caddr_n = {caddr_q[23:0], pbyte};
		else if (act && o >= 16'd16 && o <= 16'd19) yaddr_n = {yaddr_q[23:0], pbyte};
		else if (act && o >= 16'd28 && o <= 16'd33) chw_n = {chw_q[39:0], pbyte};
		else if (in_opt && phase_q == PH_LEN && pbyte != 8'd0 && !is_priv
			&& code_q == OptHost) begin
			for (int i = 0; i < HostBytes; i++) host_n[i] = 8'd0;
			hcnt_n = 6'd0;
		end else if (in_opt && phase_q == PH_VALUE) begin
			if (is_priv) begin
				if (olen_q >= 8'd18) begin
					if (ooff_q >= olen_q - 8'd17 && ooff_q <= olen_q - 8'd12)
						uplink_n = {uplink_q[39:0], pbyte};
					if (ooff_q >= olen_q - 8'd10 && ooff_q <= olen_q - 8'd7)
						iface_n = {iface_q[23:0], pbyte};
				end
			end else if (code_q == OptLease) begin
				if (olen_q >= 8'd4 && ooff_q < 8'd4) lease_n = {lease_q[23:0], pbyte};
			end else if (code_q == OptHost) begin
				if (ooff_q < 8'(HostBytes)) begin
					host_n[ooff_q[4:0]] = pbyte;
					hcnt_n = 6'(off1);
				end
			end else if (code_q == OptType) begin
				if (ooff_q == 8'd0) type_n = pbyte;
			end
		end

		summ = '0;
		summ.msg_type = type_n;
		summ.chunks = 3'd1;
		case (type_n)
			MtOffer: begin
				summ.lease_secs = lease_n; summ.station_mac = chw_n;
			end
			MtAck: begin
				summ.lease_secs = lease_n; summ.station_mac = chw_n;
				summ.station_ip = yaddr_n; summ.station_ip_valid = 1'b1;
			end
			MtDiscover, MtRequest: begin
				summ.station_ip = caddr_n; summ.station_ip_valid = 1'b1;
				summ.station_mac = chw_n; summ.relay_mac = uplink_n;
				summ.iface_tag = iface_n; summ.hostname_length = hcnt_n;
				summ.names = 1'b1;
				nch = 3'((7'(hcnt_n) + 7'd7) >> 3);
				summ.chunks = (nch == 3'd0) ? 3'd1 : nch;
			end
			MtNak, MtRelease: summ.station_mac = chw_n;
			default: ;
		endcase
		for (int i = 0; i < HostBytes; i++)
			hname[(HostBytes-1-i)*8 +: 8] = (6'(i) < hcnt_n) ? host_n[i] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; hlen_q <= '0; caddr_q <= '0; yaddr_q <= '0; chw_q <= '0;
			phase_q <= PH_CODE; code_q <= '0; olen_q <= '0; ooff_q <= '0;
			type_q <= '0; lease_q <= '1; uplink_q <= '0; iface_q <= '0;
			hcnt_q <= '0; done_q <= 1'b0;
			for (int i = 0; i < HostBytes; i++) host_q[i] <= 8'd0;
		end else if (take) begin
			if (plast) begin
				pos_q <= '0; hlen_q <= '0; caddr_q <= '0; yaddr_q <= '0; chw_q <= '0;
				phase_q <= PH_CODE; code_q <= '0; olen_q <= '0; ooff_q <= '0;
				type_q <= '0; lease_q <= '1; uplink_q <= '0; iface_q <= '0;
				hcnt_q <= '0; done_q <= 1'b0;
				for (int i = 0; i < HostBytes; i++) host_q[i] <= 8'd0;
			end else begin
				hlen_q <= hl;
				if (pos_q != 16'hFFFF) pos_q <= pos_q + 16'd1;
				caddr_q <= caddr_n; yaddr_q <= yaddr_n; chw_q <= chw_n;
				iface_q <= iface_n; lease_q <= lease_n; uplink_q <= uplink_n;
				type_q <= type_n; hcnt_q <= hcnt_n;
				host_q <= host_n;
				if (in_opt) begin
					case (phase_q)
						PH_CODE: begin
							if (pbyte == priv_code) begin
								code_q <= pbyte; phase_q <= PH_LEN;
							end else if (pbyte == OptEnd) begin
								done_q <= 1'b1;
							end else if (pbyte != OptPad) begin
								code_q <= pbyte; phase_q <= PH_LEN;
							end
						end
						PH_LEN: begin
							olen_q <= pbyte; ooff_q <= '0;
							phase_q <= (pbyte == 8'd0) ? PH_CODE : PH_VALUE;
						end
						PH_VALUE: begin
							ooff_q <= off1[7:0];
							if (off1 >= {1'b0, olen_q}) phase_q <= PH_CODE;
						end
						default: phase_q <= PH_CODE;
					endcase
				end
			end
		end
	end
endmodule

### rtl/dso_emit.sv
// result register: holds the summary and steps through hostname chunks
`timescale 1ns / 1ps
module dso_emit import dso_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input summary_t summ,
	input logic [HostBytes*8-1:0] hname,
	input logic out_stall,
	output logic busy,
	output logic valid,
	output summary_t summ_q,
	output logic [63:0] chunk,
	output logic [1:0] idx,
	output logic last
);
	logic [HostBytes*8-1:0] name_q;
	logic [1:0] idx_q;
	logic valid_q;
	logic fin;

	assign fin = (3'(idx_q) + 3'd1 >= summ_q.chunks);
	assign valid = valid_q;
	assign idx = idx_q;
	assign last = fin;
	assign chunk = summ_q.names ? name_q[HostBytes*8-1 -: 64] : 64'd0;
	// can take a new summary when empty or the final chunk leaves now
	assign busy = valid_q && !(fin && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (valid_q && !out_stall) begin
			if (fin) valid_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			summ_q <= summ;
			name_q <= hname;
		end else if (valid_q && !out_stall) begin
			name_q <= name_q << 64;
		end
	end
endmodule

### rtl/dhcp_snoop_option_parser.sv
// top level of the dhcp snooping option parser
// the result of a packet's last byte shows in the cycle after it is taken
// throughput: one byte per cycle; a packet end makes one to four results,
// and the input stalls only on a packet's last byte while earlier results are still waiting
// reset: arst_n clears all parse state but the lease, which goes to all ones; the register returns to 224
`timescale 1ns / 1ps
module dhcp_snoop_option_parser import dso_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [7:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] packet_byte,
	input logic packet_last,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] msg_type,
	output logic [31:0] lease_secs,
	output logic [31:0] station_ip,
	output logic station_ip_valid,
	output logic [47:0] station_mac,
	output logic [47:0] relay_mac,
	output logic [31:0] iface_tag,
	output logic [5:0] hostname_length,
	output logic [63:0] hostname_chunk,
	output logic [1:0] chunk_index,
	output logic last_chunk
);
	logic [7:0] priv_q;
	logic take, busy;
	summary_t summ, summ_q;
	logic [HostBytes*8-1:0] hname;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) priv_q <= PrivReset;
		else if (cfg_we) priv_q <= cfg_wdata;
	end

	// only a packet's last item needs the result register
	assign in_stall = busy && packet_last;
	assign take = in_valid && !in_stall;

	dso_parse u_parse (
		.clk(clk), .arst_n(arst_n), .take(take), .pbyte(packet_byte),
		.plast(packet_last), .priv_code(priv_q), .summ(summ), .hname(hname)
	);

	dso_emit u_emit (
		.clk(clk), .arst_n(arst_n), .load(take && packet_last), .summ(summ),
		.hname(hname), .out_stall(out_stall), .busy(busy), .valid(out_valid),
		.summ_q(summ_q), .chunk(hostname_chunk), .idx(chunk_index), .last(last_chunk)
	);

	assign msg_type = summ_q.msg_type;
	assign lease_secs = summ_q.lease_secs;
	assign station_ip = summ_q.station_ip;
	assign station_ip_valid = summ_q.station_ip_valid;
	assign station_mac = summ_q.station_mac;
	assign relay_mac = summ_q.relay_mac;
	assign iface_tag = summ_q.iface_tag;
	assign hostname_length = summ_q.hostname_length;
endmodule

### rtl/dso_checker.sv
// port-level checks for the parser, bound to the top level
`timescale 1ns / 1ps
module dso_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic packet_last,
	input logic out_valid,
	input logic out_stall,
	input logic [1:0] chunk_index,
	input logic last_chunk,
	input logic [5:0] hostname_length
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> packet_last) else $error("stall on a middle item");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_chunk |=> out_valid
		&& chunk_index == $past(chunk_index) + 2'd1) else $error("chunk order");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chunk_index != 2'd0 |-> hostname_length > 6'd8)
		else $error("extra chunk");
endmodule

bind dhcp_snoop_option_parser dso_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.packet_last(packet_last), .out_valid(out_valid), .out_stall(out_stall),
	.chunk_index(chunk_index), .last_chunk(last_chunk), .hostname_length(hostname_length)
);
